@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, result codes and the control/status bundles between the
// sorted priority queue controller and its datapath
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int FUNC_W   = 1;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int ENTRY_W   = VALUE_W + PRIO_W;
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = VALUE_W + PRIO_W + OCC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                load;
        logic                rd_head;
        logic                rd_prev;
        logic                wr_new;
        logic                wr_shift;
        logic                pop;
        logic                res_load;
        logic [STATUS_W-1:0] res_code;
    } spq_cmd_t;

    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
        logic k_zero;
        logic rd_ge;
        logic out_busy;
    } spq_sts_t;

endpackage

@@ sv/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// entry memory kept as a ring in service order, head and count registers,
// insertion index, read data register and the output register
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spq_pkg::spq_cmd_t             cmd,
    output spq_pkg::spq_sts_t             sts,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [spq_pkg::FUNC_W-1:0]    s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [spq_pkg::STATUS_W-1:0]  m_tuser
);
    import spq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0] CAP_S = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam int PAD_W = M_TDATA_W - M_FIELD_W;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] s);
        logic [IDX_W:0] r;
        r = (s >= CAP_S) ? (s - CAP_S) : s;
        return r[IDX_W-1:0];
    endfunction

    logic [ENTRY_W-1:0]  mem [CAPACITY];

    logic [FUNC_W-1:0]   func_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [PRIO_W-1:0]   pri_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [ENTRY_W-1:0]  rd_reg;
    logic [VALUE_W-1:0]  rem_val_reg;
    logic [PRIO_W-1:0]   rem_pri_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [IDX_W-1:0]    k_prev;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    head_next;
    logic [OCC_W-1:0]    occ;

    assign k_prev    = k_reg - 1'b1;
    assign wr_addr   = wrap({1'b0, head_reg} + {1'b0, k_reg});
    assign rd_addr   = cmd.rd_head ? head_reg : wrap({1'b0, head_reg} + {1'b0, k_prev});
    assign head_next = wrap({1'b0, head_reg} + (IDX_W + 1)'(1));
    assign occ       = OCC_W'(count_reg);

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            mem[wr_addr] <= {pri_reg, val_reg};
        end
        else if (cmd.wr_shift)
        begin
            mem[wr_addr] <= rd_reg;
        end
        if (cmd.rd_head || cmd.rd_prev)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= s_tuser;
            val_reg     <= s_tdata[VALUE_W-1:0];
            pri_reg     <= s_tdata[ENTRY_W-1:VALUE_W];
            rem_val_reg <= '0;
            rem_pri_reg <= '0;
        end
        else if (cmd.pop)
        begin
            rem_val_reg <= rd_reg[VALUE_W-1:0];
            rem_pri_reg <= rd_reg[ENTRY_W-1:VALUE_W];
        end
        if (cmd.res_load)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, occ, rem_pri_reg, rem_val_reg};
            m_tuser_reg <= cmd.res_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                k_reg <= IDX_W'(count_reg);
            end
            else if (cmd.wr_shift)
            begin
                k_reg <= k_prev;
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_next;
            end
            if (cmd.res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_deq   = (func_reg == FUNC_DEQ);
    assign sts.full     = (count_reg == CAP_C);
    assign sts.empty    = (count_reg == '0);
    assign sts.k_zero   = (k_reg == '0);
    assign sts.rd_ge    = (rd_reg[ENTRY_W-1:VALUE_W] >= pri_reg);
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sv/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for one queue operation: dispatch, tail-first insertion walk,
// head read on dequeue, result hand-off
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_INS_STEP = 3'd2;
    localparam logic [2:0] ST_INS_CMP  = 3'd3;
    localparam logic [2:0] ST_DEQ_POP  = 3'd4;
    localparam logic [2:0] ST_RESULT   = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STATUS_W-1:0] code_reg;
    logic [STATUS_W-1:0] code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            code_reg  <= STATUS_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.res_code = code_reg;
        state_next   = state_reg;
        code_next    = code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_deq)
                begin
                    if (sts.empty)
                    begin
                        code_next  = STATUS_EMPTY;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = ST_DEQ_POP;
                    end
                end
                else if (sts.full)
                begin
                    code_next  = STATUS_FULL;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_INS_STEP;
                end
            end
            ST_INS_STEP:
            begin
                if (sts.k_zero)
                begin
                    cmd.wr_new = 1'b1;
                    code_next  = STATUS_DONE;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                // stop behind the first entry of equal or higher priority
                if (sts.rd_ge)
                begin
                    cmd.wr_new = 1'b1;
                    code_next  = STATUS_DONE;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = ST_INS_STEP;
                end
            end
            ST_DEQ_POP:
            begin
                cmd.pop    = 1'b1;
                code_next  = STATUS_DONE;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept in service order in a ring memory
// ----------------------------------------------------------------------------
// usage
//   slave channel: one beat per operation; tuser selects enqueue or dequeue,
//   tdata carries the value and priority to enqueue
//   master channel: one beat per operation with status in tuser and the
//   removed entry and occupancy in tdata
//   a dequeue reads the head entry, pops it and then presents its result; a
//   dropped enqueue or an empty dequeue goes straight to the result; an
//   enqueue moves each held entry of lower priority back one place and
//   reads one more when an entry of equal or higher priority stays ahead
//   of it, since the insertion walks from the tail, reading the entry
//   ahead (INS_STEP) and comparing it (INS_CMP) before moving it
//   operations are handled one at a time; a new beat is taken the cycle
//   after the previous result is loaded into the output register
//   a full queue drops an enqueue, an empty queue flags a dequeue
//   reset empties the queue; memory contents are not cleared
//   while the receiver stalls the result holds and the next operation waits
//   for the output register before presenting its own result
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value, prio
    input  logic [spq_pkg::FUNC_W-1:0]    s_axis_tuser,  // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // removed_value, removed_prio, occupancy
    output logic [spq_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
    import spq_pkg::*;

    spq_cmd_t cmd;
    spq_sts_t sts;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sorted priority queue against a predictor of its own. It runs a
// short directed sequence of extreme values, ties, and dequeues on an empty
// queue, then about 1400 random operations in fill, drain and mixed phases.
// Both stream sides stall at random, and every result beat is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_OPS  = 1400;

    typedef enum logic {SLOT_OP, SLOT_PAUSE} slot_kind_e;

    typedef struct packed {
        slot_kind_e          kind;
        logic [FUNC_W-1:0]   func;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
        logic [7:0]          gap;
    } queue_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
        logic [OCC_W-1:0]    occ;
    } queue_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    queue_op_t     pending_ops[$];
    queue_result_t expected_results[$];
    queue_op_t     cur_op;

    logic [VALUE_W-1:0] held_value[CAPACITY];
    logic [PRIO_W-1:0]  held_prio[CAPACITY];
    int                 held_count = 0;

    logic in_fire = 1'b0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   send_gap = 0;
    int   hold_cnt = 0;
    int   calm_cnt = 0;
    bit   first_hold_done = 1'b0;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // value, prio
        .s_axis_tuser  (s_tuser),   // func
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // removed_value, removed_prio, occupancy
        .m_axis_tuser  (m_tuser)    // status
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
    begin
        $display("mismatch: %s", msg);
        error_count++;
    end
    endtask

    // sorted insert after every entry of equal or higher priority, pop from the head
    function automatic queue_result_t apply_queue_op(input queue_op_t op);
        queue_result_t r;
        int pos;
        r = '0;
        if (op.func == FUNC_ENQ) begin
            if (held_count >= CAPACITY) begin
                r.status = STATUS_FULL;
            end
            else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] >= op.prio)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = op.value;
                held_prio[pos]  = op.prio;
                held_count++;
                r.status = STATUS_DONE;
            end
        end
        else if (held_count == 0) begin
            r.status = STATUS_EMPTY;
        end
        else begin
            r.value = held_value[0];
            r.prio  = held_prio[0];
            for (int i = 1; i < held_count; i++) begin
                held_value[i-1] = held_value[i];
                held_prio[i-1]  = held_prio[i];
            end
            held_count--;
            r.status = STATUS_DONE;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic add_op(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] prio, input int gap);
        queue_op_t op;
    begin
        op.kind  = SLOT_OP;
        op.func  = func;
        op.value = value;
        op.prio  = prio;
        op.gap   = 8'(gap);
        pending_ops.push_back(op);
    end
    endtask

    task automatic add_pause();
        queue_op_t op;
    begin
        op = '0;
        op.kind = SLOT_PAUSE;
        pending_ops.push_back(op);
    end
    endtask

    // sender: one beat held until accepted, then the gap, then the next
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (in_fire)
                expected_results.push_back(apply_queue_op(cur_op));
            if (!s_tvalid || in_fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() != 0 && pending_ops[0].kind == SLOT_PAUSE) begin
                    if (expected_results.size() == 0)
                        void'(pending_ops.pop_front());
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() != 0) begin
                    cur_op   = pending_ops.pop_front();
                    send_gap = cur_op.gap;
                    s_tdata  <= {cur_op.prio, cur_op.value};
                    s_tuser  <= cur_op.func;
                    s_tvalid <= 1'b1;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold on the first result so the block backs up, then random stalls and calm runs
    always @(negedge clk)
    begin : receiver
        logic rdy;
        int   roll;
        rdy = 1'b1;
        if (rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (!first_hold_done && m_tvalid) begin
                first_hold_done = 1'b1;
                hold_cnt = 100;
                rdy = 1'b0;
            end
            else if (calm_cnt > 0) begin
                calm_cnt--;
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    rdy = 1'b1;
                end
                else if (roll < 85) begin
                    rdy = 1'b0;
                    hold_cnt = $urandom_range(0, 2);
                end
                else if (roll < 97) begin
                    rdy = 1'b0;
                    hold_cnt = $urandom_range(3, 10);
                end
                else if (roll < 99) begin
                    calm_cnt = $urandom_range(50, 150);
                end
                else begin
                    rdy = 1'b0;
                    hold_cnt = $urandom_range(20, 60);
                end
            end
        end
        m_tready <= rdy;
    end

    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                          m_tuser));
            end
            else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
                if (m_tdata[31:0] !== want.value)
                    report_mismatch($sformatf("removed_value got %0h want %0h",
                                              m_tdata[31:0], want.value));
                if (m_tdata[47:32] !== want.prio)
                    report_mismatch($sformatf("removed_prio got %0h want %0h",
                                              m_tdata[47:32], want.prio));
                if (m_tdata[52:48] !== want.occ)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              m_tdata[52:48], want.occ));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int next_pause;
        int mode;
        int run_len;
        int prio_style;
        int roll;
        bit calm;
        bit deq;
        logic [PRIO_W-1:0]  p;
        logic [VALUE_W-1:0] v;

        // empty dequeue, extremes and ties
        add_op(FUNC_DEQ, 32'h1234_5678, 16'hFFFF, 0);
        add_op(FUNC_ENQ, 32'h7FFF_FFFF, 16'hFFFF, 0);
        add_op(FUNC_ENQ, 32'h8000_0000, 16'h0000, 0);
        add_op(FUNC_ENQ, 32'h0000_0000, 16'hFFFF, 0);
        add_op(FUNC_ENQ, 32'hFFFF_FFFF, 16'h0000, 1);
        add_op(FUNC_ENQ, 32'h0000_0001, 16'h8000, 0);
        add_op(FUNC_ENQ, 32'h0000_0002, 16'h8000, 2);
        add_op(FUNC_ENQ, 32'h0000_0003, 16'h7FFF, 0);
        add_op(FUNC_ENQ, 32'h0000_0004, 16'hFFFF, 0);
        for (int i = 0; i < 8; i++)
            add_op(FUNC_DEQ, $urandom, 16'($urandom), pick_gap(1'b0));
        add_op(FUNC_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 0);
        add_pause();

        n = 0;
        next_pause = 350;
        while (n < RANDOM_OPS) begin
            mode       = $urandom_range(0, 2);
            run_len    = $urandom_range(20, 60);
            prio_style = $urandom_range(0, 3);
            calm       = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run_len; k++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       deq = (roll < 20);
                    1:       deq = (roll < 80);
                    default: deq = (roll < 50);
                endcase
                case (prio_style)
                    0:       p = 16'($urandom);
                    1:       p = 16'($urandom_range(0, 3));
                    2:       p = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    default: p = 16'($urandom_range(16'h7FF0, 16'h800F));
                endcase
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    v = 32'h8000_0000;
                else if (roll == 1)
                    v = 32'h7FFF_FFFF;
                else
                    v = $urandom;
                add_op(deq ? FUNC_DEQ : FUNC_ENQ, v, p, pick_gap(calm));
                n++;
            end
            if (n >= next_pause) begin
                add_pause();
                next_pause += 350;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/spq_pkg.sv
sv/spq_datapath.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
test/testbench.sv
